/* rtl/core/cdes_pkg.sv */
// ---------------------------------------------------------------------------
// cdes_pkg
// Shared types, sizes and helpers for the circular double-ended stack.
// ---------------------------------------------------------------------------
package cdes_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// Operation codes
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	// End select codes
	localparam logic END_PRIMARY = 1'b0;
	localparam logic END_REVERSE = 1'b1;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [DATA_WIDTH-1:0] data_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic issue;        // transaction accepted: update pointers, access store
		logic load_result;  // capture the finished result in the output register
	} cdes_cmd_t;

	// Add two in-range indices modulo DEPTH
	function automatic idx_t wrap_add(input idx_t a, input idx_t b);
		logic [IDX_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= (IDX_W + 1)'(DEPTH)) begin
			sum = sum - (IDX_W + 1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	// Step an index down by one, wrapping
	function automatic idx_t wrap_dec(input idx_t a);
		return (a == '0) ? IDX_W'(DEPTH - 1) : a - IDX_W'(1);
	endfunction

	// Step an index up by one, wrapping
	function automatic idx_t wrap_inc(input idx_t a);
		return (a == IDX_W'(DEPTH - 1)) ? '0 : a + IDX_W'(1);
	endfunction

endpackage

/* rtl/core/cdes_ctrl.sv */
// ---------------------------------------------------------------------------
// cdes_ctrl
// Controller: sequences each transaction through issue and result capture,
// and owns the input stall and the output valid.
// ---------------------------------------------------------------------------
module cdes_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output cdes_pkg::cdes_cmd_t cmd
);

	cdes_pkg::state_t state_q, state_nxt;
	logic             out_valid_q, out_valid_nxt;
	logic             out_free;

	// Hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cdes_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			out_valid_q <= out_valid_nxt;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	// Next state and commands
	always_comb begin
		state_nxt         = state_q;
		out_valid_nxt     = out_valid_q && out_stall;
		in_stall          = 1'b1;
		cmd.issue         = 1'b0;
		cmd.load_result   = 1'b0;
		case (state_q)
			cdes_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.issue = 1'b1;
					state_nxt = cdes_pkg::ST_EXEC;
				end
			end
			cdes_pkg::ST_EXEC: begin
				// Wait for the output register to drain, then load it
				if (out_free) begin
					cmd.load_result = 1'b1;
					out_valid_nxt   = 1'b1;
					state_nxt       = cdes_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = cdes_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/core/cdes_dpath.sv */
// ---------------------------------------------------------------------------
// cdes_dpath
// Datapath: front index and entry count, the circular store with one
// registered read port, and the result register.
// ---------------------------------------------------------------------------
module cdes_dpath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cdes_pkg::cdes_cmd_t     cmd,
	input  logic [1:0]              operation,
	input  logic                    end_select,
	input  logic [31:0]             push_value,
	output logic                    success,
	output logic [31:0]             read_value,
	output logic [6:0]              fill_count,
	output logic                    is_empty,
	output logic                    is_full
);

	cdes_pkg::data_t store_mem [cdes_pkg::DEPTH];

	cdes_pkg::idx_t  front_q, front_nxt;
	cdes_pkg::cnt_t  count_q, count_nxt;
	cdes_pkg::idx_t  acc_idx;
	cdes_pkg::data_t wr_data;
	logic            is_push, is_read, is_pop;
	logic            empty_now, full_now;
	logic            wr_en, ok;

	cdes_pkg::data_t rd_data_s1;
	logic            ok_s1;
	logic            rd_s1;

	logic            success_q;
	cdes_pkg::data_t read_value_q;
	cdes_pkg::cnt_t  fill_count_q;
	logic            is_empty_q;
	logic            is_full_q;

	assign is_push   = (operation == cdes_pkg::OP_PUSH);
	assign is_pop    = (operation == cdes_pkg::OP_POP);
	assign is_read   = is_pop || (operation == cdes_pkg::OP_PEEK);
	assign empty_now = (count_q == '0);
	assign full_now  = (count_q == cdes_pkg::CNT_W'(cdes_pkg::DEPTH));
	assign wr_data   = push_value[cdes_pkg::DATA_WIDTH-1:0];

	// Work out the entry touched and the new pointers
	always_comb begin
		acc_idx   = front_q;
		front_nxt = front_q;
		count_nxt = count_q;
		ok        = 1'b0;
		wr_en     = 1'b0;
		if (is_push && !full_now) begin
			ok        = 1'b1;
			wr_en     = 1'b1;
			count_nxt = count_q + cdes_pkg::CNT_W'(1);
			if (end_select == cdes_pkg::END_REVERSE) begin
				front_nxt = cdes_pkg::wrap_dec(front_q);
				acc_idx   = front_nxt;
			end else begin
				acc_idx = cdes_pkg::wrap_add(front_q, count_q[cdes_pkg::IDX_W-1:0]);
			end
		end else if (is_read && !empty_now) begin
			ok = 1'b1;
			if (end_select == cdes_pkg::END_REVERSE) begin
				acc_idx = front_q;
				if (is_pop) begin
					front_nxt = cdes_pkg::wrap_inc(front_q);
				end
			end else begin
				acc_idx = cdes_pkg::wrap_add(front_q,
					cdes_pkg::IDX_W'(count_q - cdes_pkg::CNT_W'(1)));
			end
			if (is_pop) begin
				count_nxt = count_q - cdes_pkg::CNT_W'(1);
			end
		end
	end

	// Advance front index and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.issue) begin
			front_q <= front_nxt;
			count_q <= count_nxt;
		end
	end

	// Write the store on a successful push
	always_ff @(posedge clk) begin
		if (cmd.issue && wr_en) begin
			store_mem[acc_idx] <= wr_data;
		end
	end

	// Read the store and register the outcome
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_data_s1 <= store_mem[acc_idx];
			ok_s1      <= ok;
			rd_s1      <= ok && is_read;
		end
	end

	// Capture the result
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			success_q    <= ok_s1;
			read_value_q <= rd_s1 ? rd_data_s1 : '0;
			fill_count_q <= count_q;
			is_empty_q   <= (count_q == '0);
			is_full_q    <= (count_q == cdes_pkg::CNT_W'(cdes_pkg::DEPTH));
		end
	end

	assign success    = success_q;
	assign read_value = 32'(read_value_q);
	assign fill_count = 7'(fill_count_q);
	assign is_empty   = is_empty_q;
	assign is_full    = is_full_q;

endmodule

/* rtl/core/circular_double_ended_stack.sv */
// ---------------------------------------------------------------------------
// circular_double_ended_stack
// Two stacks sharing one circular store from opposite ends (a deque).
// ---------------------------------------------------------------------------
// Each transaction names an end (primary top or reverse end) and pushes,
// pops or peeks; each gives exactly one result with success, the word read
// (zero on push or failure), the fill count afterwards and empty/full flags.
// A transaction has two steps: one updates the pointers and accesses the
// store, the other moves the store's registered read data into the output
// register once that is free; no new transaction is taken in between. The
// input is taken again while a finished result still waits in the output
// register. The store needs no clearing after reset.
// ---------------------------------------------------------------------------
module circular_double_ended_stack (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic        end_select,
	input  logic [31:0] push_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        success,
	output logic [31:0] read_value,
	output logic [6:0]  fill_count,
	output logic        is_empty,
	output logic        is_full
);

	cdes_pkg::cdes_cmd_t cmd;

	// Sequence transactions
	cdes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Store, pointers and result register
	cdes_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.operation  (operation),
		.end_select (end_select),
		.push_value (push_value),
		.success    (success),
		.read_value (read_value),
		.fill_count (fill_count),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

endmodule

/* rtl/core/cdes_checker.sv */
// ---------------------------------------------------------------------------
// cdes_assertions
// Port-level checks on the result channel of the double-ended stack.
// ---------------------------------------------------------------------------
module cdes_assertions (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        success,
	input logic [31:0] read_value,
	input logic [6:0]  fill_count,
	input logic        is_empty,
	input logic        is_full
);

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(fill_count))
		else $error("stalled result changed");

	// Empty flag agrees with fill count
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (fill_count == 7'd0)))
		else $error("empty flag disagrees with fill count");

	// Full flag agrees with fill count
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_full == (fill_count == 7'(cdes_pkg::DEPTH))))
		else $error("full flag disagrees with fill count");

	// A failed transaction reads zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !success |-> (read_value == 32'd0))
		else $error("failed transaction returned data");

endmodule

bind circular_double_ended_stack cdes_assertions u_cdes_assertions (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.success    (success),
	.read_value (read_value),
	.fill_count (fill_count),
	.is_empty   (is_empty),
	.is_full    (is_full)
);
